// ===== rtl/b64u_pkg.sv =====
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, codes and character mapping functions for the base64url codec.
// ----------------------------------------------------------------------------
package b64u_pkg;

   // direction register codes
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // register index of the direction register
   localparam logic REG_DIRECTION = 1'b0;

   // position inside the current group
   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;
   localparam logic [1:0] PHASE_3 = 2'd3;

   // special alphabet characters
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPZ   = 8'h5A;

   // sextet values of the two extra characters
   localparam logic [7:0] VAL_62 = 8'd62;
   localparam logic [7:0] VAL_63 = 8'd63;

   // one queued group of results caused by one input item
   typedef struct packed {
      logic       two;        // two results, else one
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       msg_last;   // message end flag for the last result
   } entry_type;

   // queue fill status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // six-bit value to alphabet character
   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, v};
      if (w <= 8'd25) begin
         c = w + 8'd65;
      end else if (w <= 8'd51) begin
         c = w + 8'd71;
      end else if (w <= 8'd61) begin
         c = w - 8'd4;
      end else if (w == VAL_62) begin
         c = CHAR_MINUS;
      end else begin
         c = CHAR_UNDER;
      end
      return c;
   endfunction

   // character to value, range arithmetic with 8-bit wrap and no checks
   function automatic logic [7:0] char_to_value(input logic [7:0] c);
      logic [7:0] d;
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         d = VAL_62;
      end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
         d = VAL_63;
      end else if (c <= CHAR_NINE) begin
         d = c + 8'd4;
      end else if (c <= CHAR_UPZ) begin
         d = c + 8'd191;
      end else begin
         d = c + 8'd185;
      end
      return d;
   endfunction

endpackage

// ===== rtl/base64url_unpadded_codec.sv =====
// Latency: a result passes through the queue and then the output register before it
// is on the rsp ports, and the second character of a pair waits until the first is taken.
// Throughput: one item per cycle when decoding or when an item gives one character,
// while results are taken and the queue is not full; encoding items that give two
// characters are held back by the single result port of the back end.
// Reset clears direction to encode, the group state, the queue and the output stage.
// ----------------------------------------------------------------------------
// base64url_unpadded_codec
// Streaming base64url encoder and decoder without padding, with an APB-style
// register port for the direction.
// ----------------------------------------------------------------------------
module base64url_unpadded_codec #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_message_end,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_message_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                   direction_ff;
   logic                   direction_in;
   logic                   csr_write;
   logic                   dir_write;
   logic                   entry_write;
   logic                   q_pop;
   b64u_pkg::entry_type    wr_entry;
   b64u_pkg::entry_type    rd_entry;
   b64u_pkg::q_status_type q_status;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign dir_write = csr_write & (paddr[2] == b64u_pkg::REG_DIRECTION);

   always_comb begin
      direction_in = direction_ff;
      if (dir_write) begin
         direction_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= b64u_pkg::DIR_ENCODE;
      end else begin
         direction_ff <= direction_in;
      end
   end

   // register read
   always_comb begin
      prdata = '0;
      if (paddr[2] == b64u_pkg::REG_DIRECTION) begin
         prdata[0] = direction_ff;
      end
   end

   b64u_front u_front (
      .clock       (clock),
      .reset       (reset),
      .clear       (dir_write),
      .direction   (direction_ff),
      .push        (push),
      .full        (full),
      .in_byte     (req_in_byte),
      .message_end (req_message_end),
      .q_status    (q_status),
      .entry_write (entry_write),
      .entry       (wr_entry)
   );

   b64u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_write),
      .wr_entry (wr_entry),
      .rd_en    (q_pop),
      .rd_entry (rd_entry),
      .status   (q_status)
   );

   b64u_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .q_entry      (rd_entry),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .out_byte     (rsp_out_byte),
      .run_last     (rsp_run_last),
      .message_last (rsp_message_last)
   );

endmodule

// ===== rtl/b64u_front.sv =====
// ----------------------------------------------------------------------------
// b64u_front
// Accepts input items, tracks group phase and forms the results of each item.
// ----------------------------------------------------------------------------
module b64u_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  direction,
   input  logic                  push,
   output logic                  full,
   input  logic [7:0]            in_byte,
   input  logic                  message_end,
   input  b64u_pkg::q_status_type q_status,
   output logic                  entry_write,
   output b64u_pkg::entry_type   entry
);

   logic [1:0] phase_ff;
   logic [1:0] phase_in;
   logic [7:0] held_ff;
   logic [7:0] held_in;
   logic       accept;
   logic       has_result;
   logic [1:0] step_phase;
   logic [7:0] step_held;
   logic [7:0] dval;

   assign full   = q_status.full;
   assign accept = push & ~q_status.full;
   assign dval   = b64u_pkg::char_to_value(in_byte);

   // result forming and next group state
   always_comb begin
      entry      = '0;
      has_result = 1'b1;
      step_phase = phase_ff;
      step_held  = held_ff;
      if (direction == b64u_pkg::DIR_ENCODE) begin
         unique case (phase_ff)
            b64u_pkg::PHASE_0, b64u_pkg::PHASE_3: begin
               entry.byte0    = b64u_pkg::sextet_to_char(in_byte[7:2]);
               entry.byte1    = b64u_pkg::sextet_to_char({in_byte[1:0], 4'b0000});
               entry.two      = message_end;
               entry.msg_last = message_end;
               step_held      = in_byte;
               step_phase     = b64u_pkg::PHASE_1;
            end
            b64u_pkg::PHASE_1: begin
               entry.byte0    = b64u_pkg::sextet_to_char({held_ff[1:0], in_byte[7:4]});
               entry.byte1    = b64u_pkg::sextet_to_char({in_byte[3:0], 2'b00});
               entry.two      = message_end;
               entry.msg_last = message_end;
               step_held      = in_byte;
               step_phase     = b64u_pkg::PHASE_2;
            end
            b64u_pkg::PHASE_2: begin
               entry.byte0    = b64u_pkg::sextet_to_char({held_ff[3:0], in_byte[7:6]});
               entry.byte1    = b64u_pkg::sextet_to_char(in_byte[5:0]);
               entry.two      = 1'b1;
               entry.msg_last = message_end;
               step_held      = 8'd0;
               step_phase     = b64u_pkg::PHASE_0;
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end else begin
         entry.two      = 1'b0;
         entry.msg_last = message_end;
         step_held      = dval;
         step_phase     = phase_ff + 2'd1;
         unique case (phase_ff)
            b64u_pkg::PHASE_0: begin
               entry.byte0 = {dval[5:0], 2'b00};
               has_result  = message_end;
            end
            b64u_pkg::PHASE_1: begin
               entry.byte0 = {held_ff[5:0], 2'b00} | {4'b0000, dval[7:4]};
            end
            b64u_pkg::PHASE_2: begin
               entry.byte0 = {held_ff[3:0], 4'b0000} | {2'b00, dval[7:2]};
            end
            b64u_pkg::PHASE_3: begin
               entry.byte0 = {held_ff[1:0], 6'b000000} | dval;
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end
   end

   assign entry_write = accept & has_result;

   // group state update, cleared at message end and on direction write
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      if (clear) begin
         phase_in = b64u_pkg::PHASE_0;
         held_in  = 8'd0;
      end else if (accept) begin
         if (message_end) begin
            phase_in = b64u_pkg::PHASE_0;
            held_in  = 8'd0;
         end else begin
            phase_in = step_phase;
            held_in  = step_held;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64u_pkg::PHASE_0;
         held_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== rtl/b64u_queue.sv =====
// ----------------------------------------------------------------------------
// b64u_queue
// Short queue of result groups between the front and the back.
// ----------------------------------------------------------------------------
module b64u_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  b64u_pkg::entry_type    wr_entry,
   input  logic                   rd_en,
   output b64u_pkg::entry_type    rd_entry,
   output b64u_pkg::q_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64u_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign rd_entry     = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      status.full |-> !(wr_en && !rd_en))
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !rd_en)
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |=> !status.empty)
      else $error("queue empty after a write");
`endif

endmodule

// ===== rtl/b64u_back.sv =====
// ----------------------------------------------------------------------------
// b64u_back
// Takes result groups from the queue and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
module b64u_back (
   input  logic                   clock,
   input  logic                   reset,
   input  b64u_pkg::q_status_type q_status,
   input  b64u_pkg::entry_type    q_entry,
   output logic                   q_pop,
   input  logic                   pop,
   output logic                   empty,
   output logic [7:0]             out_byte,
   output logic                   run_last,
   output logic                   message_last
);

   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_byte_ff;
   logic [7:0] out_byte_in;
   logic       out_run_ff;
   logic       out_run_in;
   logic       out_msg_ff;
   logic       out_msg_in;
   logic       pend_ff;
   logic       pend_in;
   logic [7:0] pend_byte_ff;
   logic [7:0] pend_byte_in;
   logic       pend_msg_ff;
   logic       pend_msg_in;
   logic       out_take;
   logic       out_free;

   assign out_take = out_valid_ff & pop;
   assign out_free = ~out_valid_ff | out_take;
   assign q_pop    = out_free & ~pend_ff & ~q_status.empty;

   assign empty        = ~out_valid_ff;
   assign out_byte     = out_byte_ff;
   assign run_last     = out_run_ff;
   assign message_last = out_msg_ff;

   // output register load: pending second result first, then the queue
   always_comb begin
      out_valid_in = out_valid_ff & ~out_take;
      out_byte_in  = out_byte_ff;
      out_run_in   = out_run_ff;
      out_msg_in   = out_msg_ff;
      pend_in      = pend_ff;
      pend_byte_in = pend_byte_ff;
      pend_msg_in  = pend_msg_ff;
      if (out_free && pend_ff) begin
         out_valid_in = 1'b1;
         out_byte_in  = pend_byte_ff;
         out_run_in   = 1'b1;
         out_msg_in   = pend_msg_ff;
         pend_in      = 1'b0;
      end else if (q_pop) begin
         out_valid_in = 1'b1;
         out_byte_in  = q_entry.byte0;
         out_run_in   = ~q_entry.two;
         out_msg_in   = ~q_entry.two & q_entry.msg_last;
         pend_in      = q_entry.two;
         pend_byte_in = q_entry.byte1;
         pend_msg_in  = q_entry.msg_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_run_ff   <= out_run_in;
      out_msg_ff   <= out_msg_in;
      pend_byte_ff <= pend_byte_in;
      pend_msg_ff  <= pend_msg_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> out_valid_ff)
      else $error("second result pending without a first one shown");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_run_ff) |-> pend_ff)
      else $error("first of two results shown without its second pending");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_msg_ff) |-> out_run_ff)
      else $error("message end flag on a result that is not the last of its item");
`endif

endmodule

// ===== verif/base64url_codec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_codec_checker
// Watches the input, result and register ports of the codec, keeps its own
// copy of the group state, predicts the characters or bytes that every
// accepted input transfer causes and compares them in order with the results.
// ----------------------------------------------------------------------------
module base64url_codec_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_message_end,
   input  logic        empty,
   input  logic        pop,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_run_last,
   input  logic        rsp_message_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          mismatch_count,
   output int          pending_count
);

   localparam logic [7:0] ASCII_ZERO    = "0";
   localparam logic [7:0] ASCII_UPPER_A = "A";
   localparam logic [7:0] ASCII_LOWER_A = "a";
   localparam logic [2:0] ADDR_DIRECTION = 3'(4 * b64u_pkg::REG_DIRECTION);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       message_last;
   } codec_output_type;

   // shadow of the direction register and the group state
   logic             direction;
   logic [1:0]       group_phase;
   logic [7:0]       held_value;
   codec_output_type expected_outputs[$];
   codec_output_type oldest;

   // six-bit value to url-safe alphabet character
   function automatic logic [7:0] alphabet_char(input logic [5:0] v);
      if (v <= 6'd25) return ASCII_UPPER_A + 8'(v);
      if (v <= 6'd51) return ASCII_LOWER_A + 8'(v) - 8'd26;
      if (v <= 6'd61) return ASCII_ZERO + 8'(v) - 8'd52;
      if (8'(v) == b64u_pkg::VAL_62) return b64u_pkg::CHAR_MINUS;
      return b64u_pkg::CHAR_UNDER;
   endfunction

   // character to value by ranges, wrapping at 8 bits and never checked
   function automatic logic [7:0] char_value(input logic [7:0] c);
      if (c == b64u_pkg::CHAR_PLUS || c == b64u_pkg::CHAR_MINUS) return b64u_pkg::VAL_62;
      if (c == b64u_pkg::CHAR_SLASH || c == b64u_pkg::CHAR_UNDER) return b64u_pkg::VAL_63;
      if (c <= b64u_pkg::CHAR_NINE) return c - ASCII_ZERO + 8'd52;
      if (c <= b64u_pkg::CHAR_UPZ) return c - ASCII_UPPER_A;
      return c - ASCII_LOWER_A + 8'd26;
   endfunction

   task automatic add_output(input logic [7:0] b, input logic run_l, input logic msg_l);
      expected_outputs.push_back('{out_byte: b, run_last: run_l, message_last: msg_l});
   endtask

   // one codec step: queue the results of one input transfer
   task automatic codec_step(input logic [7:0] b, input logic last);
      logic [1:0] ph;
      logic [7:0] d;
      ph = group_phase;
      if (direction == b64u_pkg::DIR_ENCODE) begin
         if (ph == b64u_pkg::PHASE_3) ph = b64u_pkg::PHASE_0;
         case (ph)
            b64u_pkg::PHASE_0: begin
               add_output(alphabet_char(b[7:2]), !last, 1'b0);
               if (last) add_output(alphabet_char({b[1:0], 4'b0000}), 1'b1, 1'b1);
               held_value = b;
               group_phase = b64u_pkg::PHASE_1;
            end
            b64u_pkg::PHASE_1: begin
               add_output(alphabet_char({held_value[1:0], b[7:4]}), !last, 1'b0);
               if (last) add_output(alphabet_char({b[3:0], 2'b00}), 1'b1, 1'b1);
               held_value = b;
               group_phase = b64u_pkg::PHASE_2;
            end
            default: begin
               add_output(alphabet_char({held_value[3:0], b[7:6]}), 1'b0, 1'b0);
               add_output(alphabet_char(b[5:0]), 1'b1, last);
               held_value = '0;
               group_phase = b64u_pkg::PHASE_0;
            end
         endcase
      end else begin
         d = char_value(b);
         case (ph)
            b64u_pkg::PHASE_0: begin
               if (last) add_output({d[5:0], 2'b00}, 1'b1, last);
            end
            b64u_pkg::PHASE_1: begin
               add_output({held_value[5:0], 2'b00} | {4'b0000, d[7:4]}, 1'b1, last);
            end
            b64u_pkg::PHASE_2: begin
               add_output({held_value[3:0], 4'b0000} | {2'b00, d[7:2]}, 1'b1, last);
            end
            default: begin
               add_output({held_value[1:0], 6'b000000} | d, 1'b1, last);
            end
         endcase
         held_value = d;
         group_phase = ph + 2'd1;
      end
      // end of message restarts the group
      if (last) begin
         group_phase = b64u_pkg::PHASE_0;
         held_value = '0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         direction = b64u_pkg::DIR_ENCODE;
         group_phase = b64u_pkg::PHASE_0;
         held_value = '0;
         expected_outputs.delete();
         mismatch_count = 0;
      end else begin
         // result transfer against the oldest expectation
         if (pop && !empty) begin
            if (expected_outputs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result %02h run_last %0b message_last %0b",
                           $realtime, rsp_out_byte, rsp_run_last, rsp_message_last);
            end else begin
               oldest = expected_outputs.pop_front();
               if (rsp_out_byte !== oldest.out_byte || rsp_run_last !== oldest.run_last ||
                   rsp_message_last !== oldest.message_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected %02h/%0b/%0b got %02h/%0b/%0b", $realtime,
                              oldest.out_byte, oldest.run_last, oldest.message_last,
                              rsp_out_byte, rsp_run_last, rsp_message_last);
               end
            end
         end
         // input transfer
         if (push && !full) codec_step(req_in_byte, req_message_end);
         // register access: a write also clears the group state
         if (psel && penable && pready && paddr == ADDR_DIRECTION) begin
            if (pwrite) begin
               direction = pwdata[0];
               group_phase = b64u_pkg::PHASE_0;
               held_value = '0;
            end else if (prdata !== {31'd0, direction}) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: direction read %08h, expected %0b",
                           $realtime, prdata, direction);
            end
         end
      end
      pending_count <= expected_outputs.size();
   end

endmodule

// ===== verif/tb_base64url_unpadded_codec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64url_unpadded_codec
// Drives byte and character streams into the codec in both directions with
// random gaps on both channels, switches the direction between phases over
// the register port and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_base64url_unpadded_codec;

   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 116;
   localparam logic [2:0] ADDR_DIRECTION = 3'(4 * b64u_pkg::REG_DIRECTION);
   localparam logic [7:0] ASCII_ZERO    = "0";
   localparam logic [7:0] ASCII_UPPER_A = "A";
   localparam logic [7:0] ASCII_LOWER_A = "a";

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_in_byte;
   logic        req_message_end;
   logic        empty;
   logic        pop;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_message_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          mismatch_count;
   int          pending_count;
   int          idle_cycles = 0;
   logic        send_steady = 1'b0;

   base64url_unpadded_codec u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .req_message_end  (req_message_end),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_message_last (rsp_message_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   base64url_codec_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .req_message_end  (req_message_end),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_message_last (rsp_message_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stall before each transfer, with steady stretches
   initial begin : result_taker
      int   stall;
      logic steady;
      pop <= 1'b0;
      steady = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) steady = !steady;
         stall = steady ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
      end
   end

   // one input transfer after a random gap
   task automatic send_item(input logic [7:0] b, input logic last);
      int gap;
      if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
      gap = send_steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_in_byte <= b;
      req_message_end <= last;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // write the direction, then read it back in the next transfer
   task automatic write_then_read(input logic dir);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_DIRECTION;
      pwdata <= {31'($urandom), dir};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // stop sending and wait until every result has been taken
   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      // an item without a result may still be in flight
      repeat (4) @(posedge clock);
   endtask

   task automatic change_direction(input logic dir);
      drain();
      write_then_read(dir);
   endtask

   // any character of the accepted alphabet, both variants of 62 and 63
   function automatic logic [7:0] random_alphabet_char();
      int unsigned k;
      k = $urandom_range(0, 65);
      if (k < 26) return ASCII_UPPER_A + 8'(k);
      if (k < 52) return ASCII_LOWER_A + 8'(k - 26);
      if (k < 62) return ASCII_ZERO + 8'(k - 52);
      if (k == 62) return b64u_pkg::CHAR_MINUS;
      if (k == 63) return b64u_pkg::CHAR_UNDER;
      if (k == 64) return b64u_pkg::CHAR_PLUS;
      return b64u_pkg::CHAR_SLASH;
   endfunction

   initial begin : stimulus
      int         length;
      int         sent;
      logic       dir;
      logic [7:0] value;
      reset <= 1'b1;
      push <= 1'b0;
      req_in_byte <= '0;
      req_message_end <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // encode: tails of one and two bytes, full groups, all-ones and zero bytes
      write_then_read(b64u_pkg::DIR_ENCODE);
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
      // sextets 62 and 63 give the url-safe characters
      send_item(8'hFB, 1'b0);
      send_item(8'hEF, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h12, 1'b0);
      send_item(8'h34, 1'b0);
      send_item(8'h56, 1'b0);
      send_item(8'h78, 1'b1);

      // decode: lone final character, short tails, both alphabets, wrapped codes
      change_direction(b64u_pkg::DIR_DECODE);
      send_item("Q", 1'b1);
      send_item(b64u_pkg::CHAR_PLUS, 1'b0);
      send_item(b64u_pkg::CHAR_SLASH, 1'b1);
      send_item(b64u_pkg::CHAR_MINUS, 1'b0);
      send_item(b64u_pkg::CHAR_UNDER, 1'b0);
      send_item("0", 1'b1);
      send_item("9", 1'b0);
      send_item("A", 1'b0);
      send_item("Z", 1'b0);
      send_item("a", 1'b1);
      send_item("z", 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      // partial group dropped by a direction write
      send_item("M", 1'b0);

      // random phases of messages with random content
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         dir = (p == 0) ? b64u_pkg::DIR_ENCODE
             : (p == 1) ? b64u_pkg::DIR_DECODE
             : logic'($urandom_range(0, 1));
         change_direction(dir);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 8);
            for (int i = 0; i < length; i++) begin
               // mostly valid characters when decoding, some arbitrary codes
               if (dir == b64u_pkg::DIR_DECODE && $urandom_range(0, 6) != 0)
                  value = random_alphabet_char();
               else
                  value = 8'($urandom);
               send_item(value, (i == length - 1) && ($urandom_range(0, 9) != 0));
               sent++;
            end
         end
      end

      drain();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
